// ===== design/lfp_pkg.sv =====
package lfp_pkg;

    // Frame layout
    localparam logic [7:0] HDR0         = 8'h54;
    localparam logic [7:0] HDR1         = 8'h2C;
    localparam logic [7:0] HDR_SUM      = 8'h80;    // HDR0 + HDR1, mod 256
    localparam logic [5:0] POS_BODY     = 6'd2;
    localparam logic [5:0] POS_START_LO = 6'd4;
    localparam logic [5:0] POS_START_HI = 6'd5;
    localparam logic [5:0] POS_PT_FIRST = 6'd6;
    localparam logic [5:0] POS_PT_LAST  = 6'd41;
    localparam logic [5:0] POS_END_LO   = 6'd42;
    localparam logic [5:0] POS_END_HI   = 6'd43;
    localparam logic [5:0] POS_SUM      = 6'd46;
    localparam int         FRAME_POINTS = 12;
    localparam logic [16:0] FULL_TURN   = 17'd36000;

    // Byte slot within one point record
    localparam logic [1:0] SUB_DLO = 2'd0;
    localparam logic [1:0] SUB_DHI = 2'd1;
    localparam logic [1:0] SUB_INT = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_HDR1 = 3'b010,
        PH_BODY = 3'b100
    } phase_t;

    typedef enum logic [7:0] {
        ST_RX    = 8'b0000_0001,
        ST_READ  = 8'b0000_0010,
        ST_TEST  = 8'b0000_0100,
        ST_DIV   = 8'b0000_1000,
        ST_ADD   = 8'b0001_0000,
        ST_MOD   = 8'b0010_0000,
        ST_PUSH  = 8'b0100_0000,
        ST_FLUSH = 8'b1000_0000
    } state_t;

endpackage

// ===== design/lfp_ram.sv =====
module lfp_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 12,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/lidar_frame_parser.sv =====
// Channel   Dir  Ports                                              Transaction
// --------  ---  -------------------------------------------------  ---------------------------
// input     in   s_valid s_ready s_rx_byte                          one received serial byte
// result    out  m_valid m_ready m_angle_cdeg m_distance_mm         one kept point of a frame
//                m_intensity m_last_point
// config    in   cfg_valid cfg_ready cfg_data                       range_limit_mm write
//
// Flow: while receiving, one byte is taken every cycle. After the checksum byte of a
//   good frame s_ready drops for the point run: a skipped point is read and tested; a
//   kept point is read, tested, scaled by reciprocal multiply, added, reduced in 1 to 4
//   modulo passes and pushed; then a flush step. Push and flush wait out m_ready stalls.
// Reset: synchronous, active low; parser back to header hunt, limit to 12000.
// Stalls: m_ready low holds the output register; the next point waits in a holding register.
module lidar_frame_parser
    import lfp_pkg::*;
#(
    parameter int N_PTS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // points
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_angle_cdeg,
    output logic [15:0] m_distance_mm,
    output logic [7:0]  m_intensity,
    output logic        m_last_point,
    // range limit register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int DENOM  = (N_PTS > 1) ? N_PTS - 1 : 1;
    localparam int K_W    = $clog2(N_PTS + 1);
    localparam int AW     = (N_PTS > 1) ? $clog2(N_PTS) : 1;
    localparam int MAG_W  = 16 + K_W;            // |span * k| < 2^16 * 2^K_W
    localparam int ACC_W  = MAG_W + 1;
    // floor(x / DENOM) = (x * RCP_M) >> RCP_SH for every x below 2^MAG_W
    localparam int RCP_SH = MAG_W + $clog2(DENOM);
    localparam int RCP_INT = ((1 << RCP_SH) + DENOM - 1) / DENOM;
    localparam int PROD_W = RCP_SH + MAG_W;
    localparam logic [ACC_W-1:0] RCP_M = ACC_W'(RCP_INT);

    // ---------------- registers ----------------
    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [5:0]          pos_reg, pos_next;
    logic [7:0]          csum_reg, csum_next;
    logic [15:0]         start_reg, start_next;
    logic [15:0]         end_reg, end_next;
    logic [1:0]          sub_reg, sub_next;
    logic [3:0]          pidx_reg, pidx_next;
    logic [7:0]          dlo_reg, dlo_next;
    logic [7:0]          dhi_reg, dhi_next;
    logic [15:0]         limit_reg, limit_next;

    logic [K_W-1:0]      k_reg, k_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;   // span * k
    logic signed [17:0]  span_reg, span_next;
    logic                neg_reg, neg_next;
    logic [MAG_W-1:0]    quo_reg, quo_next;
    logic [16:0]         ang_reg, ang_next;
    logic [15:0]         cur_dist_reg, cur_dist_next;
    logic [7:0]          cur_int_reg, cur_int_next;

    logic                held_valid_reg, held_valid_next;
    logic [15:0]         held_ang_reg, held_ang_next;
    logic [15:0]         held_dist_reg, held_dist_next;
    logic [7:0]          held_int_reg, held_int_next;

    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_ang_reg, m_ang_next;
    logic [15:0]         m_dist_reg, m_dist_next;
    logic [7:0]          m_int_reg, m_int_next;
    logic                m_last_reg, m_last_next;

    // ---------------- point store ----------------
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [23:0]         ram_wdata;
    logic [23:0]         ram_rdata;

    lfp_ram #(
        .DATA_W (24),
        .DEPTH  (N_PTS),
        .ADDR_W (AW)
    ) u_pt_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (k_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ---------------- shared arithmetic ----------------
    logic                s_fire;
    logic                out_free;
    logic                last_k;
    logic signed [16:0]  span_raw;
    logic [PROD_W-1:0]   rcp_prod;
    logic [15:0]         q16;
    logic signed [17:0]  q_signed;
    logic signed [17:0]  ang_sum;
    logic [MAG_W-1:0]    acc_mag;
    logic [15:0]         rd_dist;

    assign s_ready   = (state_reg == ST_RX);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_k    = (k_reg == K_W'(N_PTS - 1));

    // end - start; wrapped once into the turn when it is captured into span_reg
    assign span_raw  = $signed({1'b0, end_reg}) - $signed({1'b0, start_reg});

    // reciprocal multiply, 20 x 21 significant bits at 12 points
    assign rcp_prod  = PROD_W'(quo_reg) * PROD_W'(RCP_M);

    // quotient magnitude is at most 65535
    assign q16       = quo_reg[15:0];
    assign q_signed  = neg_reg ? -$signed({2'b00, q16}) : $signed({2'b00, q16});
    assign ang_sum   = $signed({2'b00, start_reg}) + q_signed;

    assign acc_mag   = acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
    assign rd_dist   = ram_rdata[15:0];

    // RAM write: full point record at its intensity byte
    assign ram_we    = s_fire && (phase_reg == PH_BODY) && (sub_reg == SUB_INT)
                       && (pos_reg inside {[POS_PT_FIRST:POS_PT_LAST]})
                       && (pidx_reg < 4'(N_PTS));
    assign ram_waddr = pidx_reg[AW-1:0];
    assign ram_wdata = {s_rx_byte, dhi_reg, dlo_reg};

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        csum_next       = csum_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        sub_next        = sub_reg;
        pidx_next       = pidx_reg;
        dlo_next        = dlo_reg;
        dhi_next        = dhi_reg;
        limit_next      = limit_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        span_next       = span_reg;
        neg_next        = neg_reg;
        quo_next        = quo_reg;
        ang_next        = ang_reg;
        cur_dist_next   = cur_dist_reg;
        cur_int_next    = cur_int_reg;
        held_valid_next = held_valid_reg;
        held_ang_next   = held_ang_reg;
        held_dist_next  = held_dist_reg;
        held_int_next   = held_int_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ang_next      = m_ang_reg;
        m_dist_next     = m_dist_reg;
        m_int_next      = m_int_reg;
        m_last_next     = m_last_reg;

        if (cfg_valid) begin
            limit_next = cfg_data;
        end

        case (state_reg)
            ST_RX: begin
                if (s_fire) begin
                    case (phase_reg)
                        PH_HUNT: begin
                            if (s_rx_byte == HDR0) begin
                                phase_next = PH_HDR1;
                            end
                        end
                        PH_HDR1: begin
                            if (s_rx_byte == HDR1) begin
                                phase_next = PH_BODY;
                                pos_next   = POS_BODY;
                                csum_next  = HDR_SUM;
                            end else if (s_rx_byte != HDR0) begin
                                phase_next = PH_HUNT;
                            end
                        end
                        PH_BODY: begin
                            // field capture
                            if (pos_reg == POS_START_LO) start_next[7:0]  = s_rx_byte;
                            if (pos_reg == POS_START_HI) begin
                                start_next[15:8] = s_rx_byte;
                                sub_next         = SUB_DLO;
                                pidx_next        = '0;
                            end
                            if (pos_reg == POS_END_LO) end_next[7:0]  = s_rx_byte;
                            if (pos_reg == POS_END_HI) end_next[15:8] = s_rx_byte;
                            if (pos_reg inside {[POS_PT_FIRST:POS_PT_LAST]}) begin
                                case (sub_reg)
                                    SUB_DLO: begin
                                        dlo_next = s_rx_byte;
                                        sub_next = SUB_DHI;
                                    end
                                    SUB_DHI: begin
                                        dhi_next = s_rx_byte;
                                        sub_next = SUB_INT;
                                    end
                                    default: begin
                                        sub_next  = SUB_DLO;
                                        pidx_next = pidx_reg + 4'd1;
                                    end
                                endcase
                            end

                            if (pos_reg < POS_SUM) begin
                                csum_next = csum_reg + s_rx_byte;
                                pos_next  = pos_reg + 6'd1;
                            end else begin
                                phase_next = PH_HUNT;
                                pos_next   = '0;
                                csum_next  = '0;
                                if (csum_reg == s_rx_byte) begin
                                    span_next  = span_raw[16]
                                                 ? 18'(span_raw) + 18'(FULL_TURN)
                                                 : 18'(span_raw);
                                    k_next          = '0;
                                    acc_next        = '0;
                                    held_valid_next = 1'b0;
                                    state_next      = ST_READ;
                                end
                            end
                        end
                        default: begin
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                            csum_next  = '0;
                        end
                    endcase
                end
            end

            ST_READ: begin
                // address k on the RAM; data next cycle
                state_next = ST_TEST;
            end

            ST_TEST: begin
                cur_dist_next = rd_dist;
                cur_int_next  = ram_rdata[23:16];
                if (rd_dist == 16'd0 || rd_dist > limit_reg) begin
                    acc_next   = acc_reg + ACC_W'(span_reg);
                    k_next     = k_reg + K_W'(1);
                    state_next = last_k ? ST_FLUSH : ST_READ;
                end else begin
                    neg_next   = acc_reg[ACC_W-1];
                    quo_next   = acc_mag;
                    state_next = ST_DIV;
                end
            end

            ST_DIV: begin
                // |span * k| / DENOM, truncated; sign is put back in the add
                quo_next   = rcp_prod[RCP_SH +: MAG_W];
                state_next = ST_ADD;
            end

            ST_ADD: begin
                // never negative for 16-bit angles; clamp kept for safety
                ang_next   = ang_sum[17] ? 17'd0 : ang_sum[16:0];
                state_next = ST_MOD;
            end

            ST_MOD: begin
                // at most three passes: sum < 4 * 36000
                if (ang_reg >= FULL_TURN) begin
                    ang_next = ang_reg - FULL_TURN;
                end else begin
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH: begin
                if (!held_valid_reg || out_free) begin
                    if (held_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_ang_next   = held_ang_reg;
                        m_dist_next  = held_dist_reg;
                        m_int_next   = held_int_reg;
                        m_last_next  = 1'b0;
                    end
                    held_valid_next = 1'b1;
                    held_ang_next   = ang_reg[15:0];
                    held_dist_next  = cur_dist_reg;
                    held_int_next   = cur_int_reg;
                    acc_next        = acc_reg + ACC_W'(span_reg);
                    k_next          = k_reg + K_W'(1);
                    state_next      = last_k ? ST_FLUSH : ST_READ;
                end
            end

            ST_FLUSH: begin
                if (!held_valid_reg) begin
                    state_next = ST_RX;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_ang_next      = held_ang_reg;
                    m_dist_next     = held_dist_reg;
                    m_int_next      = held_int_reg;
                    m_last_next     = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_RX;
                end
            end

            default: begin
                state_next = ST_RX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RX;
            phase_reg      <= PH_HUNT;
            pos_reg        <= '0;
            csum_reg       <= '0;
            sub_reg        <= SUB_DLO;
            pidx_reg       <= '0;
            limit_reg      <= 16'd12000;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            csum_reg       <= csum_next;
            sub_reg        <= sub_next;
            pidx_reg       <= pidx_next;
            limit_reg      <= limit_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg     <= start_next;
        end_reg       <= end_next;
        dlo_reg       <= dlo_next;
        dhi_reg       <= dhi_next;
        k_reg         <= k_next;
        acc_reg       <= acc_next;
        span_reg      <= span_next;
        neg_reg       <= neg_next;
        quo_reg       <= quo_next;
        ang_reg       <= ang_next;
        cur_dist_reg  <= cur_dist_next;
        cur_int_reg   <= cur_int_next;
        held_ang_reg  <= held_ang_next;
        held_dist_reg <= held_dist_next;
        held_int_reg  <= held_int_next;
        m_ang_reg     <= m_ang_next;
        m_dist_reg    <= m_dist_next;
        m_int_reg     <= m_int_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_angle_cdeg  = m_ang_reg;
    assign m_distance_mm = m_dist_reg;
    assign m_intensity   = m_int_reg;
    assign m_last_point  = m_last_reg;

endmodule
